### design/grid_min_cost_path_unit_macros.svh
// Assertion helpers shared by the grid path unit.
`ifndef GRID_MIN_COST_PATH_UNIT_MACROS_SVH
`define GRID_MIN_COST_PATH_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GMCP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GMCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/gmcp_pkg.sv
`default_nettype none

package gmcp_pkg;

    localparam int COST_W     = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    // wide enough for any effective count up to the largest supported grid side
    localparam int LIM_W      = 13;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 8'd1;

    localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 8'd1;

    typedef logic signed [COST_W-1:0] t_cost;

    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last;
    } t_cell_ctl;

endpackage

`default_nettype wire

### design/gmcp_if.sv
`default_nettype none

interface gmcp_cell_if #(parameter int VALUE_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmcp_cost_if;
    logic                              valid;
    logic                              ready;
    logic signed [gmcp_pkg::COST_W-1:0] min_cost;

    modport source (output valid, output min_cost, input ready);
    modport sink   (input valid, input min_cost, output ready);
endinterface

interface gmcp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gmcp_pkg::CFG_IDX_W-1:0]     reg_index;
    logic [gmcp_pkg::CFG_DATA_W-1:0]    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

### design/gmcp_line_buf.sv
`default_nettype none

module gmcp_line_buf #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_rd_en,
    input  wire logic [ADDR_W-1:0]   i_rd_addr,
    output gmcp_pkg::t_cost          o_rd_data,
    input  wire logic                i_wr_en,
    input  wire logic [ADDR_W-1:0]   i_wr_addr,
    input  gmcp_pkg::t_cost          i_wr_data
);
    import gmcp_pkg::*;

    t_cost r_mem [DEPTH];
    t_cost r_rd_data;
    t_cost r_fwd_data;
    logic  r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // read and write to one entry in the same cycle: hand over the new value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

### design/gmcp_cost_core.sv
`default_nettype none

module gmcp_cost_core #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic                          i_clear,
    input  gmcp_pkg::t_cell_ctl                i_ctl,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    input  gmcp_pkg::t_cost                    i_up,
    output gmcp_pkg::t_cost                    o_best
);
    import gmcp_pkg::*;

    localparam int SUM_W = ((VALUE_WIDTH > COST_W) ? VALUE_WIDTH : COST_W) + 2;
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-COST_W+1){1'b0}}, {(COST_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-COST_W+1){1'b1}}, {(COST_W-1){1'b0}}};

    t_cost r_left_best;
    t_cost r_diag_best;
    t_cost n_left_best;
    t_cost n_diag_best;

    t_cost                   w_pick;
    t_cost                   w_min_ul;
    logic signed [SUM_W-1:0] w_sum;

    always_comb begin
        w_min_ul = (r_left_best < i_up) ? r_left_best : i_up;
        if (i_ctl.first_row && i_ctl.first_col) begin
            w_pick = '0;
        end else if (i_ctl.first_row) begin
            w_pick = r_left_best;
        end else if (i_ctl.first_col) begin
            w_pick = i_up;
        end else begin
            w_pick = (r_diag_best < w_min_ul) ? r_diag_best : w_min_ul;
        end
        w_sum = {{(SUM_W-VALUE_WIDTH){i_value[VALUE_WIDTH-1]}}, i_value}
              + {{(SUM_W-COST_W){w_pick[COST_W-1]}}, w_pick};
        if (w_sum > SAT_MAX) begin
            o_best = SAT_MAX[COST_W-1:0];
        end else if (w_sum < SAT_MIN) begin
            o_best = SAT_MIN[COST_W-1:0];
        end else begin
            o_best = w_sum[COST_W-1:0];
        end
    end

    always_comb begin
        n_left_best = r_left_best;
        n_diag_best = r_diag_best;
        if (i_clear) begin
            n_left_best = '0;
            n_diag_best = '0;
        end else if (i_step) begin
            if (i_ctl.last) begin
                n_left_best = '0;
                n_diag_best = '0;
            end else begin
                n_left_best = o_best;
                n_diag_best = i_up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_best <= '0;
            r_diag_best <= '0;
        end else begin
            r_left_best <= n_left_best;
            r_diag_best <= n_diag_best;
        end
    end

endmodule

`default_nettype wire

### design/grid_min_cost_path_unit.sv
// Minimum path cost over a grid of signed cell costs, moves down, right or
// down-right. Cells enter row-major on i_cell; row and column counts are
// written on i_cfg (a count of zero acts as one, a count above the maximum as
// the maximum) and every write to either count restarts the grid. One cell
// is taken per clock cycle: a cell's read of the previous row's best cost
// from the line-buffer memory is issued on acceptance and the add/compare
// completes in the registered cell stage, with the result for the grid's
// last cell passing through the output register to o_cost. Input stalls
// only while a finished result is still waiting on o_cost and the next last
// cell is ready to complete, or while a configuration write is offered on
// i_cfg. Configuration writes are taken whenever no cell is in flight.
`default_nettype none

`include "grid_min_cost_path_unit_macros.svh"

module grid_min_cost_path_unit #(
    parameter int MAX_ROWS    = 128,
    parameter int MAX_COLS    = 128,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    gmcp_cell_if.sink       i_cell,
    gmcp_cost_if.source     o_cost,
    gmcp_cfg_if.sink        i_cfg
);
    import gmcp_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [CFG_DATA_W-1:0] r_row_count;
    logic [CFG_DATA_W-1:0] r_col_count;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;

    logic                          r_s0_valid;
    t_cell_ctl                     r_s0_ctl;
    logic signed [VALUE_WIDTH-1:0] r_s0_value;
    logic [COL_W-1:0]              r_s0_col;

    logic  r_out_valid;
    t_cost r_out_cost;

    logic [LIM_W-1:0] w_row_lim;
    logic [LIM_W-1:0] w_col_lim;
    logic [LIM_W-1:0] w_row_last;
    logic [LIM_W-1:0] w_col_last;
    logic             w_at_last_row;
    logic             w_at_last_col;
    logic             w_cfg_acc;
    logic             w_cfg_hit;
    logic             w_in_acc;
    logic             w_consume;
    t_cell_ctl        w_ctl;
    t_cost            w_up;
    t_cost            w_best;

    // effective counts
    always_comb begin
        if (r_row_count == '0) begin
            w_row_lim = LIM_W'(1);
        end else if (LIM_W'(r_row_count) > LIM_W'(MAX_ROWS)) begin
            w_row_lim = LIM_W'(MAX_ROWS);
        end else begin
            w_row_lim = LIM_W'(r_row_count);
        end
        if (r_col_count == '0) begin
            w_col_lim = LIM_W'(1);
        end else if (LIM_W'(r_col_count) > LIM_W'(MAX_COLS)) begin
            w_col_lim = LIM_W'(MAX_COLS);
        end else begin
            w_col_lim = LIM_W'(r_col_count);
        end
        w_row_last    = w_row_lim - LIM_W'(1);
        w_col_last    = w_col_lim - LIM_W'(1);
        w_at_last_row = (LIM_W'(r_row) == w_row_last);
        w_at_last_col = (LIM_W'(r_col) == w_col_last);
        w_ctl.first_row = (r_row == '0);
        w_ctl.first_col = (r_col == '0);
        w_ctl.last      = w_at_last_row && w_at_last_col;
    end

    assign w_consume = r_s0_valid && (!r_s0_ctl.last || !r_out_valid || o_cost.ready);

    assign i_cfg.ready  = !r_s0_valid;
    assign i_cell.ready = (!r_s0_valid || w_consume) && !i_cfg.valid;

    assign w_cfg_acc = i_cfg.valid && i_cfg.ready;
    assign w_cfg_hit = w_cfg_acc
        && ((i_cfg.reg_index == REG_ROW_COUNT) || (i_cfg.reg_index == REG_COL_COUNT));
    assign w_in_acc  = i_cell.valid && i_cell.ready;

    // configuration and grid position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= COUNT_RESET;
            r_col_count <= COUNT_RESET;
            r_row       <= '0;
            r_col       <= '0;
        end else if (w_cfg_hit) begin
            if (i_cfg.reg_index == REG_ROW_COUNT) begin
                r_row_count <= i_cfg.wr_data;
            end else begin
                r_col_count <= i_cfg.wr_data;
            end
            r_row <= '0;
            r_col <= '0;
        end else if (w_in_acc) begin
            if (w_at_last_col) begin
                r_col <= '0;
                r_row <= w_at_last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // cell stage: holds the cell while its line-buffer read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s0_valid <= 1'b1;
        end else if (w_consume) begin
            r_s0_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s0_ctl   <= w_ctl;
            r_s0_value <= i_cell.cell_value;
            r_s0_col   <= r_col;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume && r_s0_ctl.last) begin
            r_out_valid <= 1'b1;
        end else if (o_cost.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && r_s0_ctl.last) begin
            r_out_cost <= w_best;
        end
    end

    assign o_cost.valid    = r_out_valid;
    assign o_cost.min_cost = r_out_cost;

    gmcp_line_buf #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (w_up),
        .i_wr_en   (w_consume),
        .i_wr_addr (r_s0_col),
        .i_wr_data (w_best)
    );

    gmcp_cost_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cost_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_consume),
        .i_clear (w_cfg_hit),
        .i_ctl   (r_s0_ctl),
        .i_value (r_s0_value),
        .i_up    (w_up),
        .o_best  (w_best)
    );

    `GMCP_ASSERT_NEXT(a_pos_wraps, i_clk, i_rst_n, w_in_acc && w_ctl.last,
        (r_row == '0) && (r_col == '0), "position not back at origin after last cell")
    `GMCP_ASSERT_SAME(a_fwd_one_col, i_clk, i_rst_n,
        w_in_acc && w_consume && (r_s0_col == r_col), w_col_last == '0,
        "same-entry read and write outside a one-column grid")
    `GMCP_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_cost.ready,
        !(w_consume && r_s0_ctl.last), "pending result overwritten")
    `GMCP_ASSERT_SAME(a_cfg_idle, i_clk, i_rst_n, w_cfg_acc,
        !r_s0_valid && !w_in_acc, "config write taken with a cell in flight")

endmodule

`default_nettype wire

### test/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gmcp_pkg::*;

    localparam int     MAX_R       = 128;
    localparam int     MAX_C       = 128;
    localparam int     VALUE_W     = 16;
    localparam int     CLK_PERIOD  = 10;
    localparam int     RST_CYCLES  = 12;
    localparam int     LAT_PAD     = 4;
    localparam int     STALL_LIMIT = 2000;
    localparam int     HOLD_CYCLES = 300;
    localparam longint COST_MAX    = (longint'(1) <<< (COST_W - 1)) - 1;
    localparam longint COST_MIN    = -(longint'(1) <<< (COST_W - 1));

    logic clk = 1'b0;
    logic rst_n;

    gmcp_cell_if #(.VALUE_WIDTH(VALUE_W)) cell_if ();
    gmcp_cost_if                          cost_if ();
    gmcp_cfg_if                           cfg_if ();

    grid_min_cost_path_unit #(
        .MAX_ROWS    (MAX_R),
        .MAX_COLS    (MAX_C),
        .VALUE_WIDTH (VALUE_W)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cell  (cell_if),
        .o_cost  (cost_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Path cost predictor state
    t_cost       line_cost [MAX_C] = '{default: '0};
    t_cost       left_cost = '0;
    t_cost       diag_cost = '0;
    int unsigned grid_row  = 0;
    int unsigned grid_col  = 0;
    logic [CFG_DATA_W-1:0] rows_reg = COUNT_RESET;
    logic [CFG_DATA_W-1:0] cols_reg = COUNT_RESET;

    t_cost cost_q [$];
    t_cost want_cost;
    int    err_cnt      = 0;
    int    cells_sent   = 0;
    int    tx_idle_pct  = 0;
    int    rx_stall_pct = 0;
    int    rx_cycle     = 0;
    int    hold_end     = 0;
    bit    need_cfg     = 1'b1;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic int unsigned eff_count(input logic [CFG_DATA_W-1:0] raw,
                                              input int unsigned lim);
        if (raw == 0) return 1;
        if (raw > lim) return lim;
        return 32'(raw);
    endfunction

    function automatic int unsigned grid_size();
        return eff_count(rows_reg, MAX_R) * eff_count(cols_reg, MAX_C);
    endfunction

    // Advance the predictor by one cell; returns 1 when the grid completes.
    function automatic logic predict_cell(input logic signed [VALUE_W-1:0] v,
                                          output t_cost cost);
        int unsigned rows, cols, c;
        longint      up, lo, sum;
        rows = eff_count(rows_reg, MAX_R);
        cols = eff_count(cols_reg, MAX_C);
        c    = grid_col;
        if (c >= cols) c = cols - 1;
        if (grid_row >= rows) grid_row = rows - 1;
        up = longint'(line_cost[c]);

        if (grid_row == 0 && c == 0) begin
            sum = longint'(v);
        end else if (grid_row == 0) begin
            sum = longint'(v) + longint'(left_cost);
        end else if (c == 0) begin
            sum = longint'(v) + up;
        end else begin
            lo = up;
            if (longint'(left_cost) < lo) lo = longint'(left_cost);
            if (longint'(diag_cost) < lo) lo = longint'(diag_cost);
            sum = longint'(v) + lo;
        end
        if (sum > COST_MAX) sum = COST_MAX;
        if (sum < COST_MIN) sum = COST_MIN;

        cost         = t_cost'(sum);
        diag_cost    = t_cost'(up);
        left_cost    = cost;
        line_cost[c] = cost;

        if (c + 1 >= cols) begin
            grid_col = 0;
            if (grid_row + 1 >= rows) begin
                grid_row  = 0;
                left_cost = '0;
                diag_cost = '0;
                return 1'b1;
            end
            grid_row++;
        end else begin
            grid_col = c + 1;
        end
        return 1'b0;
    endfunction

    // valid is left high after a transfer so back-to-back cells need one assignment
    task automatic send_cell(input logic signed [VALUE_W-1:0] v);
        t_cost cost;
        if ($urandom_range(99) < tx_idle_pct) begin
            cell_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        cell_if.valid      <= 1'b1;
        cell_if.cell_value <= v;
        do @(posedge clk); while (!cell_if.ready);
        if (predict_cell(v, cost)) cost_q.push_back(cost);
        cells_sent++;
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_cell();
        case ($urandom_range(15))
            0:       return {1'b1, {(VALUE_W - 1){1'b0}}};
            1:       return {1'b0, {(VALUE_W - 1){1'b1}}};
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic send_grid(input int unsigned n);
        repeat (n) send_cell(rand_cell());
    endtask

    // Drop valid, let every pending result drain, then cover the pipeline.
    task automatic wait_idle();
        cell_if.valid <= 1'b0;
        @(posedge clk);
        while (cost_q.size() != 0) @(posedge clk);
        repeat (LAT_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= data;
        do @(posedge clk); while (!cfg_if.ready);
        if (idx == REG_ROW_COUNT) rows_reg = data;
        else if (idx == REG_COL_COUNT) cols_reg = data;
        else return;
        grid_row  = 0;
        grid_col  = 0;
        left_cost = '0;
        diag_cost = '0;
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] rows,
                            input logic [CFG_DATA_W-1:0] cols);
        wait_idle();
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COL_COUNT, cols);
        // unmapped index at a grid boundary: must leave everything alone
        if ($urandom_range(7) == 0)
            write_reg(CFG_IDX_W'($urandom_range(255, REG_COL_COUNT + 1)),
                      CFG_DATA_W'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)  return '0;
        if (r < 90) return CFG_DATA_W'($urandom_range(5, 1));
        return CFG_DATA_W'($urandom_range(12, 6));
    endfunction

    task automatic test_single_cells();
        set_grid(1, 1);
        send_cell(16'sh8000);
        send_cell(16'sh7fff);
        send_cell(16'sh0000);
        send_cell(16'shffff);
        send_cell(16'sh0001);
        send_cell(16'sh5555);
        send_cell(16'shaaaa);
    endtask

    task automatic test_small_grids();
        set_grid(2, 2);
        send_cell(16'sh7fff);
        send_cell(16'sh8000);
        send_cell(16'sh8000);
        send_cell(16'sh7fff);
        set_grid(2, 3);
        send_cell(16'sd5);
        send_cell(-16'sd3);
        send_cell(16'sd7);
        send_cell(16'sd2);
        send_cell(-16'sd8);
        send_cell(16'sd1);
    endtask

    task automatic test_zero_counts();
        set_grid(0, 0);
        send_grid(2);
        set_grid(0, 3);
        send_grid(3);
    endtask

    task automatic test_restart_mid_grid();
        set_grid(2, 2);
        send_grid(3);
        wait_idle();
        write_reg(REG_COL_COUNT, 1);
        cfg_if.valid <= 1'b0;
        send_grid(2);
    endtask

    task automatic test_count_limits();
        // above-max row count clamps; long column of max and min costs
        set_grid(255, 1);
        repeat (grid_size()) send_cell(16'sh7fff);
        repeat (grid_size()) send_cell(16'sh8000);
        set_grid(1, 128);
        send_grid(grid_size());
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        set_grid(1, 1);
        hold_end = rx_cycle + HOLD_CYCLES;
        send_grid(40);
        wait_idle();
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int target);
        int          start;
        int unsigned n;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start        = cells_sent;
        need_cfg     = 1'b1;
        while (cells_sent - start < target) begin
            if (need_cfg || $urandom_range(9) < 7) set_grid(pick_count(), pick_count());
            n = grid_size();
            if ($urandom_range(9) == 0 && n > 1) begin
                send_grid($urandom_range(n - 1, 1));
                wait_idle();
                need_cfg = 1'b1;
            end else begin
                send_grid(n);
                need_cfg = 1'b0;
            end
        end
        wait_idle();
    endtask

    initial begin
        rst_n              <= 1'b0;
        cell_if.valid      <= 1'b0;
        cell_if.cell_value <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.reg_index   <= '0;
        cfg_if.wr_data     <= '0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_cells();
        test_small_grids();
        test_zero_counts();
        test_restart_mid_grid();
        test_count_limits();
        test_output_backpressure();
        test_random_phase(0, 0, 170);
        test_random_phase(67, 0, 170);
        test_random_phase(0, 67, 170);
        test_random_phase(16, 16, 170);

        wait_idle();
        if (cost_q.size() != 0)
            report_error($sformatf("%0d expected costs never arrived", cost_q.size()));
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Cost sink: random stalls plus a long hold-off window, checks each transfer
    always @(posedge clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle < hold_end) cost_if.ready <= 1'b0;
        else cost_if.ready <= ($urandom_range(99) >= rx_stall_pct);

        if (cost_if.valid && cost_if.ready) begin
            if (cost_q.size() == 0) begin
                report_error($sformatf("unexpected cost %0d", cost_if.min_cost));
            end else begin
                want_cost = cost_q.pop_front();
                if (cost_if.min_cost !== want_cost)
                    report_error($sformatf("min_cost got %0d want %0d",
                                           cost_if.min_cost, want_cost));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((cell_if.valid && cell_if.ready) || (cost_if.valid && cost_if.ready)
                    || (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR @%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/gmcp_pkg.sv
design/gmcp_if.sv
design/gmcp_line_buf.sv
design/gmcp_cost_core.sv
design/grid_min_cost_path_unit.sv
test/tb_top.sv
